// ----- hw/rtl/c8_pkg.sv -----
package c8_pkg;

   // Storage sizes.
   localparam int MEM_BYTES   = 4096;
   localparam int FRAME_BYTES = 256;
   localparam int STACK_DEPTH = 16;
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int FB_AW       = $clog2(FRAME_BYTES);
   localparam int SP_IW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PC_W        = 13;
   localparam int SP_W        = 5;

   // Display geometry: 64 pixels to a row, 2048 pixels in all.
   localparam int ROW_SHIFT = 6;
   localparam int PIX_LIMIT = 2048;

   localparam logic [PC_W-1:0]   PC_RESET  = 13'h200;
   localparam logic [MEM_AW-1:0] FONT_BASE = 12'h050;
   localparam int                FONT_BYTES = 80;

   localparam logic [7:0] BCD_HUNDRED = 8'd100;
   localparam logic [7:0] BCD_TEN     = 8'd10;

   // Instruction classes by top nibble.
   localparam logic [3:0] OPC_SYS      = 4'h0;
   localparam logic [3:0] OPC_JUMP     = 4'h1;
   localparam logic [3:0] OPC_CALL     = 4'h2;
   localparam logic [3:0] OPC_SKEQ_IMM = 4'h3;
   localparam logic [3:0] OPC_SKNE_IMM = 4'h4;
   localparam logic [3:0] OPC_SKEQ_REG = 4'h5;
   localparam logic [3:0] OPC_LOAD_IMM = 4'h6;
   localparam logic [3:0] OPC_ADD_IMM  = 4'h7;
   localparam logic [3:0] OPC_ALU      = 4'h8;
   localparam logic [3:0] OPC_SKNE_REG = 4'h9;
   localparam logic [3:0] OPC_LOAD_I   = 4'hA;
   localparam logic [3:0] OPC_JUMP_V0  = 4'hB;
   localparam logic [3:0] OPC_RAND     = 4'hC;
   localparam logic [3:0] OPC_DRAW     = 4'hD;
   localparam logic [3:0] OPC_KEY      = 4'hE;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   // Low bytes of the Fx group.
   localparam logic [7:0] FX_GET_DT   = 8'h07;
   localparam logic [7:0] FX_WAIT_KEY = 8'h0A;
   localparam logic [7:0] FX_SET_DT   = 8'h15;
   localparam logic [7:0] FX_SET_ST   = 8'h18;
   localparam logic [7:0] FX_ADD_I    = 8'h1E;
   localparam logic [7:0] FX_FONT     = 8'h29;
   localparam logic [7:0] FX_BCD      = 8'h33;
   localparam logic [7:0] FX_STORE    = 8'h55;
   localparam logic [7:0] FX_LOAD     = 8'h65;

   // Sub-operation codes of the 8xyN group.
   localparam logic [3:0] ALU_N_MOV  = 4'h0;
   localparam logic [3:0] ALU_N_OR   = 4'h1;
   localparam logic [3:0] ALU_N_AND  = 4'h2;
   localparam logic [3:0] ALU_N_XOR  = 4'h3;
   localparam logic [3:0] ALU_N_ADD  = 4'h4;
   localparam logic [3:0] ALU_N_SUB  = 4'h5;
   localparam logic [3:0] ALU_N_SHR  = 4'h6;
   localparam logic [3:0] ALU_N_RSUB = 4'h7;
   localparam logic [3:0] ALU_N_SHL  = 4'hE;

   typedef enum logic [1:0] {
      MODE_WRITE,
      MODE_READ,
      MODE_FRAME,
      MODE_EXEC
   } mode_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_MOV,
      ALU_OR,
      ALU_AND,
      ALU_XOR,
      ALU_ADD,
      ALU_SUB,
      ALU_SHR,
      ALU_RSUB,
      ALU_SHL
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] res;
      logic       flag;
      logic       flagged;
      logic       write;
      logic       eq;
      logic       ge;
   } alu_rsp_type;

   // Hex digit font, five rows per digit.
   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

endpackage

// ----- hw/rtl/chip8_interpreter_core.sv -----
// Items: memory write, memory or frame read, most instructions, BCD, register
// block store or load, and sprite drawing row by row and pixel by pixel, with a
// read-modify-write of the frame byte for each set pixel on screen.
// Throughput: one item at a time, set by the single memory port and shared ALU.
// Reset is synchronous; afterwards a sweep over all 4096 bytes loads memory with zeros
// and the font before the first item is accepted.
module chip8_interpreter_core import c8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_keys,
   input  logic [7:0]  req_random_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [12:0] rsp_program_counter,
   output logic [15:0] rsp_executed_opcode,
   output logic        rsp_waiting_key,
   output logic        rsp_fault,
   output logic [7:0]  rsp_sound_timer
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RDMEM, S_RDFB, S_FETCH1, S_FETCH2, S_READX, S_READY,
      S_EXEC, S_SETF, S_BCD_H, S_BCD_T, S_BCD_W0, S_BCD_W1, S_BCD_W2,
      S_STORE, S_LOAD_RD, S_LOAD_WR, S_DRAW_ROW, S_DRAW_LINE, S_DRAW_PIX,
      S_DRAW_RMW, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [MEM_AW-1:0]  clr_ff, clr_in;
   mode_type           mode_ff, mode_in;
   logic [11:0]        addr_ff, addr_in;
   logic [15:0]        keys_ff, keys_in;
   logic [7:0]         rnd_ff, rnd_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [15:0]        i_ff, i_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [7:0]         dt_ff, dt_in;
   logic [7:0]         st_ff, st_in;
   logic [15:0]        op_ff, op_in;
   logic [7:0]         a_ff, a_in;
   logic [7:0]         b_ff, b_in;
   logic               flag_ff, flag_in;
   logic               hit_ff, hit_in;
   logic [3:0]         idx_ff, idx_in;
   logic [1:0]         hund_ff, hund_in;
   logic [3:0]         tens_ff, tens_in;
   logic [7:0]         line_ff, line_in;
   logic [3:0]         row_ff, row_in;
   logic [8:0]         rowy_ff, rowy_in;
   logic [2:0]         col_ff, col_in;
   logic [7:0]         rdata_ff, rdata_in;
   logic               wait_ff, wait_in;
   logic               fault_ff, fault_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_read_data_ff;
   logic [PC_W-1:0]    rsp_pc_ff;
   logic [15:0]        rsp_op_ff;
   logic               rsp_wait_ff;
   logic               rsp_fault_ff;
   logic [7:0]         rsp_sound_ff;
   logic               rsp_load;

   logic [7:0]         v_ff [16];
   logic               v_we;
   logic [3:0]         v_wa;
   logic [7:0]         v_wd;
   logic [3:0]         v_ra;
   logic [7:0]         v_rd;

   logic [PC_W-1:0]    stack_ff [STACK_DEPTH];
   logic               stk_we;
   logic [SP_IW-1:0]   stk_push_idx;
   logic [SP_IW-1:0]   stk_pop_idx;
   logic [SP_W-1:0]    sp_dec;

   logic               mem_we;
   logic [MEM_AW-1:0]  mem_wa;
   logic [7:0]         mem_wd;
   logic [MEM_AW-1:0]  mem_ra;
   logic [7:0]         mem_q;

   logic [FRAME_BYTES-1:0] fb_valid_ff;
   logic               fb_vq_ff;
   logic               fb_clear;
   logic               fb_we;
   logic [FB_AW-1:0]   fb_wa;
   logic [7:0]         fb_wd;
   logic [FB_AW-1:0]   fb_ra;
   logic [7:0]         fb_q;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;

   logic [3:0]         op_x;
   logic [3:0]         op_y;
   logic [3:0]         op_n;
   logic [7:0]         op_kk;
   logic [11:0]        op_nnn;
   logic [PC_W-1:0]    pc_skip;
   logic [MEM_AW-1:0]  font_off;
   logic [15:0]        pix;
   logic [7:0]         pix_mask;
   logic [7:0]         fb_old;
   logic               pix_bit;
   logic               key_pressed;

   // Lowest pressed key.
   function automatic logic [3:0] first_key(input logic [15:0] k);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (k[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

   // Map the 8xyN sub-code onto the shared unit.
   function automatic alu_op_type alu_map(input logic [3:0] n);
      alu_op_type r;
      unique case (n)
         ALU_N_MOV:  r = ALU_MOV;
         ALU_N_OR:   r = ALU_OR;
         ALU_N_AND:  r = ALU_AND;
         ALU_N_XOR:  r = ALU_XOR;
         ALU_N_ADD:  r = ALU_ADD;
         ALU_N_SUB:  r = ALU_SUB;
         ALU_N_SHR:  r = ALU_SHR;
         ALU_N_RSUB: r = ALU_RSUB;
         ALU_N_SHL:  r = ALU_SHL;
         default:    r = ALU_NOP;
      endcase
      return r;
   endfunction

   c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_wa),
      .wdata (mem_wd),
      .raddr (mem_ra),
      .rdata (mem_q)
   );

   c8_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_mem (
      .clock (clock),
      .we    (fb_we),
      .waddr (fb_wa),
      .wdata (fb_wd),
      .raddr (fb_ra),
      .rdata (fb_q)
   );

   c8_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Instruction fields and small derived values.
   assign op_x         = op_ff[11:8];
   assign op_y         = op_ff[7:4];
   assign op_n         = op_ff[3:0];
   assign op_kk        = op_ff[7:0];
   assign op_nnn       = op_ff[11:0];
   assign pc_skip      = pc_ff + PC_W'(2);
   assign font_off     = clr_ff - FONT_BASE;
   assign sp_dec       = sp_ff - SP_W'(1);
   assign stk_push_idx = sp_ff[SP_IW-1:0];
   assign stk_pop_idx  = sp_dec[SP_IW-1:0];
   assign pix          = 16'({rowy_ff, ROW_SHIFT'(0)}) + 16'(a_ff) + 16'(col_ff);
   assign pix_mask     = 8'(1) << pix[2:0];
   assign fb_old       = fb_vq_ff ? fb_q : 8'd0;
   assign pix_bit      = line_ff[3'd7 - col_ff];
   assign key_pressed  = keys_ff[a_ff[3:0]];
   assign v_rd         = v_ff[v_ra];
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = (state_ff != S_IDLE);

   // Shared unit operand selection.
   always_comb begin
      alu_req.op = ALU_NOP;
      alu_req.a  = a_ff;
      alu_req.b  = b_ff;
      if (state_ff == S_BCD_H) begin
         alu_req.op = ALU_SUB;
         alu_req.b  = BCD_HUNDRED;
      end else if (state_ff == S_BCD_T) begin
         alu_req.op = ALU_SUB;
         alu_req.b  = BCD_TEN;
      end else if (op_ff[15:12] == OPC_ALU) begin
         alu_req.op = alu_map(op_n);
      end else if (op_ff[15:12] == OPC_ADD_IMM) begin
         alu_req.op = ALU_ADD;
         alu_req.b  = op_kk;
      end else if (op_ff[15:12] == OPC_SKEQ_IMM || op_ff[15:12] == OPC_SKNE_IMM) begin
         alu_req.b  = op_kk;
      end
   end

   // Register file read address.
   always_comb begin
      priority case (state_ff)
         S_READY: v_ra = (op_ff[15:12] == OPC_JUMP_V0) ? 4'd0 : op_y;
         S_STORE: v_ra = idx_ff;
         default: v_ra = op_x;
      endcase
   end

   // Sequencer next state and datapath controls.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      mode_in  = mode_ff;
      addr_in  = addr_ff;
      keys_in  = keys_ff;
      rnd_in   = rnd_ff;
      pc_in    = pc_ff;
      i_in     = i_ff;
      sp_in    = sp_ff;
      dt_in    = dt_ff;
      st_in    = st_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      flag_in  = flag_ff;
      hit_in   = hit_ff;
      idx_in   = idx_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      line_in  = line_ff;
      row_in   = row_ff;
      rowy_in  = rowy_ff;
      col_in   = col_ff;
      rdata_in = rdata_ff;
      wait_in  = wait_ff;
      fault_in = fault_ff;

      mem_we   = 1'b0;
      mem_wa   = req_address;
      mem_wd   = req_write_data;
      mem_ra   = (mode_type'(req_mode) == MODE_EXEC) ? pc_ff[MEM_AW-1:0] : req_address;
      fb_we    = 1'b0;
      fb_wa    = pix[FB_AW+2:3];
      fb_wd    = fb_old ^ pix_mask;
      fb_ra    = req_address[FB_AW-1:0];
      fb_clear = 1'b0;
      v_we     = 1'b0;
      v_wa     = op_x;
      v_wd     = alu_rsp.res;
      stk_we   = 1'b0;

      unique case (state_ff)
         // Load zeros and the font, one byte a cycle.
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff >= FONT_BASE && font_off < MEM_AW'(FONT_BYTES)) ?
                     FONT_ROM[font_off[6:0]] : 8'd0;
            clr_in = clr_ff + MEM_AW'(1);
            if (clr_ff == MEM_AW'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               mode_in  = mode_type'(req_mode);
               addr_in  = req_address;
               keys_in  = req_keys;
               rnd_in   = req_random_value;
               op_in    = 16'd0;
               rdata_in = 8'd0;
               wait_in  = 1'b0;
               fault_in = 1'b0;
               unique case (mode_type'(req_mode))
                  MODE_WRITE: begin
                     mem_we   = 1'b1;
                     state_in = S_DONE;
                  end
                  MODE_READ:  state_in = S_RDMEM;
                  MODE_FRAME: state_in = S_RDFB;
                  MODE_EXEC: begin
                     if (pc_ff >= PC_W'(MEM_BYTES - 1)) begin
                        fault_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FETCH1;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_RDMEM: begin
            rdata_in = mem_q;
            state_in = S_DONE;
         end

         S_RDFB: begin
            rdata_in = (addr_ff < 12'(FRAME_BYTES)) ? fb_old : 8'd0;
            state_in = S_DONE;
         end

         // Instruction fetch, high byte then low byte.
         S_FETCH1: begin
            op_in[15:8] = mem_q;
            mem_ra      = pc_ff[MEM_AW-1:0] + MEM_AW'(1);
            state_in    = S_FETCH2;
         end

         S_FETCH2: begin
            op_in[7:0] = mem_q;
            pc_in      = pc_ff + PC_W'(2);
            state_in   = S_READX;
         end

         S_READX: begin
            a_in     = v_rd;
            state_in = S_READY;
         end

         S_READY: begin
            b_in     = v_rd;
            state_in = S_EXEC;
         end

         // Decode and execute.
         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff[15:12])
               OPC_SYS: begin
                  if (op_ff == OP_CLS) begin
                     fb_clear = 1'b1;
                  end else if (op_ff == OP_RET && sp_ff != SP_W'(0)) begin
                     sp_in = sp_dec;
                     pc_in = stack_ff[stk_pop_idx];
                  end
               end
               OPC_JUMP: pc_in = PC_W'(op_nnn);
               OPC_CALL: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     fault_in = 1'b1;
                  end else begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SP_W'(1);
                     pc_in  = PC_W'(op_nnn);
                  end
               end
               OPC_SKEQ_IMM, OPC_SKEQ_REG: begin
                  if (alu_rsp.eq) begin
                     pc_in = pc_skip;
                  end
               end
               OPC_SKNE_IMM, OPC_SKNE_REG: begin
                  if (!alu_rsp.eq) begin
                     pc_in = pc_skip;
                  end
               end
               OPC_LOAD_IMM: begin
                  v_we = 1'b1;
                  v_wd = op_kk;
               end
               OPC_ADD_IMM: v_we = 1'b1;
               OPC_ALU: begin
                  v_we    = alu_rsp.write;
                  flag_in = alu_rsp.flag;
                  if (alu_rsp.flagged) begin
                     state_in = S_SETF;
                  end
               end
               OPC_LOAD_I: i_in = 16'(op_nnn);
               OPC_JUMP_V0: pc_in = PC_W'(b_ff) + PC_W'(op_nnn);
               OPC_RAND: begin
                  v_we = 1'b1;
                  v_wd = rnd_ff & op_kk;
               end
               OPC_DRAW: begin
                  hit_in   = 1'b0;
                  row_in   = 4'd0;
                  rowy_in  = {1'b0, b_ff};
                  state_in = S_DRAW_ROW;
               end
               OPC_KEY: begin
                  if ((op_kk == KEY_DOWN && key_pressed) || (op_kk == KEY_UP && !key_pressed)) begin
                     pc_in = pc_skip;
                  end
               end
               default: begin
                  priority case (op_kk)
                     FX_GET_DT: begin
                        v_we = 1'b1;
                        v_wd = dt_ff;
                     end
                     FX_WAIT_KEY: begin
                        if (keys_ff == 16'd0) begin
                           wait_in = 1'b1;
                           pc_in   = pc_ff - PC_W'(2);
                        end else begin
                           v_we = 1'b1;
                           v_wd = 8'(first_key(keys_ff));
                        end
                     end
                     FX_SET_DT: dt_in = a_ff;
                     FX_SET_ST: st_in = a_ff;
                     FX_ADD_I:  i_in = i_ff + 16'(a_ff);
                     FX_FONT:   i_in = 16'({a_ff, 2'b00}) + 16'(a_ff) + 16'(FONT_BASE);
                     FX_BCD: begin
                        hund_in  = 2'd0;
                        tens_in  = 4'd0;
                        state_in = S_BCD_H;
                     end
                     FX_STORE: begin
                        idx_in   = 4'd0;
                        state_in = S_STORE;
                     end
                     FX_LOAD: begin
                        idx_in   = 4'd0;
                        state_in = S_LOAD_RD;
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            endcase
         end

         // Flag write after the result of an 8xyN operation.
         S_SETF: begin
            v_we     = 1'b1;
            v_wa     = 4'hF;
            v_wd     = {7'd0, flag_ff};
            state_in = S_DONE;
         end

         // Decimal digits by repeated subtraction.
         S_BCD_H: begin
            if (alu_rsp.ge) begin
               a_in    = alu_rsp.res;
               hund_in = hund_ff + 2'd1;
            end else begin
               state_in = S_BCD_T;
            end
         end

         S_BCD_T: begin
            if (alu_rsp.ge) begin
               a_in    = alu_rsp.res;
               tens_in = tens_ff + 4'd1;
            end else begin
               state_in = S_BCD_W0;
            end
         end

         S_BCD_W0: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[MEM_AW-1:0];
            mem_wd   = {6'd0, hund_ff};
            state_in = S_BCD_W1;
         end

         S_BCD_W1: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[MEM_AW-1:0] + MEM_AW'(1);
            mem_wd   = {4'd0, tens_ff};
            state_in = S_BCD_W2;
         end

         S_BCD_W2: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[MEM_AW-1:0] + MEM_AW'(2);
            mem_wd   = a_ff;
            state_in = S_DONE;
         end

         // Register block store, one register a cycle.
         S_STORE: begin
            mem_we = 1'b1;
            mem_wa = i_ff[MEM_AW-1:0] + MEM_AW'(idx_ff);
            mem_wd = v_rd;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == op_x) begin
               state_in = S_DONE;
            end
         end

         // Register block load, read then write back.
         S_LOAD_RD: begin
            mem_ra   = i_ff[MEM_AW-1:0] + MEM_AW'(idx_ff);
            state_in = S_LOAD_WR;
         end

         S_LOAD_WR: begin
            v_we   = 1'b1;
            v_wa   = idx_ff;
            v_wd   = mem_q;
            idx_in = idx_ff + 4'd1;
            state_in = (idx_ff == op_x) ? S_DONE : S_LOAD_RD;
         end

         // Sprite rows come from memory at I plus the row number.
         S_DRAW_ROW: begin
            if (row_ff == op_n) begin
               v_we     = 1'b1;
               v_wa     = 4'hF;
               v_wd     = {7'd0, hit_ff};
               state_in = S_DONE;
            end else begin
               mem_ra   = i_ff[MEM_AW-1:0] + MEM_AW'(row_ff);
               state_in = S_DRAW_LINE;
            end
         end

         S_DRAW_LINE: begin
            line_in  = mem_q;
            col_in   = 3'd0;
            state_in = S_DRAW_PIX;
         end

         // Set pixels on screen get a read-modify-write of their frame byte.
         S_DRAW_PIX, S_DRAW_RMW: begin
            if (state_ff == S_DRAW_PIX && pix_bit && pix < 16'(PIX_LIMIT)) begin
               fb_ra    = pix[FB_AW+2:3];
               state_in = S_DRAW_RMW;
            end else begin
               if (state_ff == S_DRAW_RMW) begin
                  fb_we = 1'b1;
                  if ((fb_old & pix_mask) != 8'd0) begin
                     hit_in = 1'b1;
                  end
               end
               col_in = col_ff + 3'd1;
               if (col_ff == 3'd7) begin
                  row_in   = row_ff + 4'd1;
                  rowy_in  = rowy_ff + 9'd1;
                  state_in = S_DRAW_ROW;
               end else begin
                  state_in = S_DRAW_PIX;
               end
            end
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Result beat register.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= PC_RESET;
         i_ff         <= '0;
         sp_ff        <= '0;
         dt_ff        <= '0;
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         sp_ff        <= sp_in;
         dt_ff        <= dt_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      addr_ff  <= addr_in;
      keys_ff  <= keys_in;
      rnd_ff   <= rnd_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      flag_ff  <= flag_in;
      hit_ff   <= hit_in;
      idx_ff   <= idx_in;
      hund_ff  <= hund_in;
      tens_ff  <= tens_in;
      line_ff  <= line_in;
      row_ff   <= row_in;
      rowy_ff  <= rowy_in;
      col_ff   <= col_in;
      rdata_ff <= rdata_in;
      wait_ff  <= wait_in;
      fault_ff <= fault_in;
      fb_vq_ff <= fb_valid_ff[fb_ra];
      if (rsp_load) begin
         rsp_read_data_ff <= (mode_ff == MODE_READ || mode_ff == MODE_FRAME) ? rdata_ff : 8'd0;
         rsp_pc_ff        <= pc_ff;
         rsp_op_ff        <= op_ff;
         rsp_wait_ff      <= wait_ff;
         rsp_fault_ff     <= fault_ff;
         rsp_sound_ff     <= st_ff;
      end
   end

   // Data registers, one write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            v_ff[k] <= 8'd0;
         end
      end else if (v_we) begin
         v_ff[v_wa] <= v_wd;
      end
   end

   // Return stack.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_ff[stk_push_idx] <= pc_ff;
      end
   end

   // Frame byte valid bits: an unwritten byte reads as zero.
   always_ff @(posedge clock) begin
      if (reset || fb_clear) begin
         fb_valid_ff <= '0;
      end else if (fb_we) begin
         fb_valid_ff[fb_wa] <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_executed_opcode = rsp_op_ff;
   assign rsp_waiting_key     = rsp_wait_ff;
   assign rsp_fault           = rsp_fault_ff;
   assign rsp_sound_timer     = rsp_sound_ff;

`ifndef ASSERT_OFF
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer past stack depth");

   a_wait_opcode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_waiting_key) |->
      (rsp_executed_opcode[15:12] == 4'hF && rsp_executed_opcode[7:0] == FX_WAIT_KEY))
      else $error("key wait reported for another instruction");

   a_read_no_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_data != 8'd0) |->
      (rsp_executed_opcode == 16'd0 && !rsp_fault))
      else $error("read data on an execute beat");
`endif

endmodule

// ----- hw/rtl/c8_ram.sv -----
module c8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ----- hw/rtl/c8_alu.sv -----
module c8_alu import c8_pkg::*; (
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [8:0] sum;
   logic [8:0] diff;
   logic [8:0] rdiff;

   // Shared 8-bit unit for register arithmetic, compares and digit steps.
   always_comb begin
      sum   = {1'b0, req.a} + {1'b0, req.b};
      diff  = {1'b0, req.a} - {1'b0, req.b};
      rdiff = {1'b0, req.b} - {1'b0, req.a};
      rsp.eq      = (req.a == req.b);
      rsp.ge      = !diff[8];
      rsp.res     = req.a;
      rsp.flag    = 1'b0;
      rsp.flagged = 1'b1;
      rsp.write   = 1'b1;
      unique case (req.op)
         ALU_NOP: begin
            rsp.flagged = 1'b0;
            rsp.write   = 1'b0;
         end
         ALU_MOV: begin
            rsp.res     = req.b;
            rsp.flagged = 1'b0;
         end
         ALU_OR: begin
            rsp.res     = req.a | req.b;
            rsp.flagged = 1'b0;
         end
         ALU_AND: begin
            rsp.res     = req.a & req.b;
            rsp.flagged = 1'b0;
         end
         ALU_XOR: begin
            rsp.res     = req.a ^ req.b;
            rsp.flagged = 1'b0;
         end
         ALU_ADD: begin
            rsp.res  = sum[7:0];
            rsp.flag = sum[8];
         end
         ALU_SUB: begin
            rsp.res  = diff[7:0];
            rsp.flag = !diff[8] && (req.a != req.b);
         end
         ALU_SHR: begin
            rsp.res  = {1'b0, req.a[7:1]};
            rsp.flag = req.a[0];
         end
         ALU_RSUB: begin
            rsp.res  = rdiff[7:0];
            rsp.flag = !rdiff[8] && (req.a != req.b);
         end
         ALU_SHL: begin
            rsp.res  = {req.a[6:0], 1'b0};
            rsp.flag = req.a[7];
         end
         default: begin
            rsp.flagged = 1'b0;
            rsp.write   = 1'b0;
         end
      endcase
   end

endmodule

// ----- test/testbench.sv -----
module testbench import c8_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [12:0] program_counter;
      logic [15:0] opcode;
      logic        waiting_key;
      logic        fault;
      logic [7:0]  sound_timer;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = 2'd0;
   logic [11:0] req_address = 12'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic [15:0] req_keys = 16'd0;
   logic [7:0]  req_random_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [12:0] rsp_program_counter;
   logic [15:0] rsp_executed_opcode;
   logic        rsp_waiting_key;
   logic        rsp_fault;
   logic [7:0]  rsp_sound_timer;

   chip8_interpreter_core u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the processor state.
   logic [7:0]  shadow_mem [MEM_BYTES];
   logic [7:0]  shadow_frame [FRAME_BYTES];
   logic [7:0]  shadow_v [16];
   logic [12:0] shadow_stack [16];
   int          shadow_sp;
   logic [15:0] shadow_i;
   logic [12:0] shadow_pc;
   logic [7:0]  shadow_delay;
   logic [7:0]  shadow_sound;

   beat_type expected_beats [$];
   int  mismatches = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   int  hold_cycles = 0;
   int  burst_cycles = 0;

   // Run one item through the shadow state and return the beat it should give.
   task automatic cpu_predict(input logic [1:0] mode, input logic [11:0] addr,
                              input logic [7:0] wdata, input logic [15:0] keys,
                              input logic [7:0] rnd, output beat_type b);
      logic [15:0] op;
      int x, y, n, kk, nnn, cx, cy, p;
      logic [7:0] a, bb, r, f, line, m;
      bit flagged, pressed;
      b = '0;
      if (mode == MODE_WRITE) begin
         shadow_mem[addr] = wdata;
      end else if (mode == MODE_READ) begin
         b.read_data = shadow_mem[addr];
      end else if (mode == MODE_FRAME) begin
         b.read_data = (addr < FRAME_BYTES) ? shadow_frame[addr] : 8'd0;
      end else if (int'(shadow_pc) + 1 >= MEM_BYTES) begin
         b.fault = 1'b1;
      end else begin
         op = {shadow_mem[shadow_pc], shadow_mem[shadow_pc + 1]};
         b.opcode = op;
         shadow_pc = shadow_pc + 13'd2;
         x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
         case (op[15:12])
            OPC_SYS: begin
               if (op == OP_CLS) begin
                  foreach (shadow_frame[k]) shadow_frame[k] = 8'd0;
               end else if (op == OP_RET && shadow_sp > 0) begin
                  shadow_sp--;
                  shadow_pc = shadow_stack[shadow_sp];
               end
            end
            OPC_JUMP: shadow_pc = 13'(nnn);
            OPC_CALL: begin
               if (shadow_sp >= STACK_DEPTH) begin
                  b.fault = 1'b1;
               end else begin
                  shadow_stack[shadow_sp] = shadow_pc;
                  shadow_sp++;
                  shadow_pc = 13'(nnn);
               end
            end
            OPC_SKEQ_IMM: if (shadow_v[x] == kk) shadow_pc += 13'd2;
            OPC_SKNE_IMM: if (shadow_v[x] != kk) shadow_pc += 13'd2;
            OPC_SKEQ_REG: if (shadow_v[x] == shadow_v[y]) shadow_pc += 13'd2;
            OPC_LOAD_IMM: shadow_v[x] = 8'(kk);
            OPC_ADD_IMM:  shadow_v[x] = shadow_v[x] + 8'(kk);
            OPC_ALU: begin
               a = shadow_v[x]; bb = shadow_v[y]; f = 8'd0; flagged = 1'b1;
               case (4'(n))
                  ALU_N_MOV: begin r = bb; flagged = 1'b0; end
                  ALU_N_OR:  begin r = a | bb; flagged = 1'b0; end
                  ALU_N_AND: begin r = a & bb; flagged = 1'b0; end
                  ALU_N_XOR: begin r = a ^ bb; flagged = 1'b0; end
                  ALU_N_ADD: begin r = a + bb; f = (int'(a) + int'(bb) > 255); end
                  ALU_N_SUB: begin r = a - bb; f = (a > bb); end
                  ALU_N_SHR: begin r = a >> 1; f = a[0]; end
                  ALU_N_RSUB: begin r = bb - a; f = (bb > a); end
                  ALU_N_SHL: begin r = a << 1; f = a[7]; end
                  default: begin r = a; flagged = 1'b0; n = -1; end
               endcase
               if (n >= 0) begin
                  shadow_v[x] = r;
                  if (flagged) shadow_v[15] = f;
               end
            end
            OPC_SKNE_REG: if (shadow_v[x] != shadow_v[y]) shadow_pc += 13'd2;
            OPC_LOAD_I:   shadow_i = 16'(nnn);
            OPC_JUMP_V0:  shadow_pc = 13'(int'(shadow_v[0]) + nnn);
            OPC_RAND:     shadow_v[x] = rnd & 8'(kk);
            OPC_DRAW: begin
               cx = shadow_v[x]; cy = shadow_v[y];
               shadow_v[15] = 8'd0;
               for (int i = 0; i < n; i++) begin
                  line = shadow_mem[12'(int'(shadow_i) + i)];
                  for (int j = 0; j < 8; j++) begin
                     if (line[7-j]) begin
                        p = (cy + i) * 64 + cx + j;
                        if (p < PIX_LIMIT) begin
                           m = 8'd1 << (p % 8);
                           if ((shadow_frame[p / 8] & m) != 0) shadow_v[15] = 8'd1;
                           shadow_frame[p / 8] ^= m;
                        end
                     end
                  end
               end
            end
            OPC_KEY: begin
               pressed = keys[shadow_v[x][3:0]];
               if ((kk == KEY_DOWN && pressed) || (kk == KEY_UP && !pressed))
                  shadow_pc += 13'd2;
            end
            default: begin
               case (8'(kk))
                  FX_GET_DT: shadow_v[x] = shadow_delay;
                  FX_WAIT_KEY: begin
                     if (keys == 16'd0) begin
                        b.waiting_key = 1'b1;
                        shadow_pc -= 13'd2;
                     end else begin
                        for (int k = 15; k >= 0; k--) if (keys[k]) shadow_v[x] = 8'(k);
                     end
                  end
                  FX_SET_DT: shadow_delay = shadow_v[x];
                  FX_SET_ST: shadow_sound = shadow_v[x];
                  FX_ADD_I:  shadow_i = shadow_i + shadow_v[x];
                  FX_FONT:   shadow_i = 16'(int'(shadow_v[x]) * 5 + FONT_BASE);
                  FX_BCD: begin
                     shadow_mem[12'(shadow_i)]     = shadow_v[x] / 100;
                     shadow_mem[12'(shadow_i + 1)] = shadow_v[x] / 10 % 10;
                     shadow_mem[12'(shadow_i + 2)] = shadow_v[x] % 10;
                  end
                  FX_STORE: for (int k = 0; k <= x; k++) shadow_mem[12'(int'(shadow_i) + k)] = shadow_v[k];
                  FX_LOAD:  for (int k = 0; k <= x; k++) shadow_v[k] = shadow_mem[12'(int'(shadow_i) + k)];
                  default: ;
               endcase
            end
         endcase
      end
      b.program_counter = shadow_pc;
      b.sound_timer = shadow_sound;
   endtask

   // Offer one beat; returns at the edge that accepted it.
   task automatic send_item(input logic [1:0] mode, input logic [11:0] addr,
                            input logic [7:0] wdata, input logic [15:0] keys,
                            input logic [7:0] rnd);
      beat_type b;
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= addr;
      req_write_data <= wdata;
      req_keys <= keys;
      req_random_value <= rnd;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      cpu_predict(mode, addr, wdata, keys, rnd, b);
      expected_beats.push_back(b);
      beats_sent++;
   endtask

   function automatic logic [15:0] rand_keys();
      return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
   endfunction

   // Place an instruction at the current program counter and run it.
   task automatic run_op(input logic [15:0] op, input logic [15:0] keys = 16'hFFFF);
      send_item(MODE_WRITE, 12'(shadow_pc), op[15:8], 16'($urandom), 8'($urandom_range(0, 254)));
      send_item(MODE_WRITE, 12'(shadow_pc + 1), op[7:0], 16'($urandom),
                8'($urandom_range(0, 254)));
      send_item(MODE_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom_range(0, 254)));
   endtask

   task automatic test_memory();
      send_item(MODE_WRITE, 12'h000, 8'hFF, 16'h0000, 8'h00);
      send_item(MODE_WRITE, 12'hFFF, 8'hA5, 16'hFFFF, 8'hFE);
      send_item(MODE_READ, 12'h000, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_READ, 12'h050, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_READ, 12'h09F, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_FRAME, 12'h000, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_FRAME, 12'h0FF, 8'h00, 16'h0000, 8'h00);
      send_item(MODE_FRAME, 12'hFFF, 8'h00, 16'h0000, 8'h00);
   endtask

   task automatic test_instructions();
      logic [15:0] alu_codes [10] = '{16'h0, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5,
                                     16'h6, 16'h7, 16'hE, 16'h8};
      run_op({OPC_LOAD_IMM, 12'h0FF});
      run_op({OPC_LOAD_IMM, 12'h101});
      foreach (alu_codes[k]) run_op({OPC_ALU, 8'h01, alu_codes[k][3:0]});
      run_op({OPC_LOAD_IMM, 12'hF80});
      run_op({OPC_ALU, 4'hF, 4'hF, ALU_N_SHL});
      run_op({OPC_ADD_IMM, 12'h0FF});
      run_op({OPC_SKEQ_IMM, 12'h000});
      run_op({OPC_SKNE_IMM, 12'h000});
      run_op({OPC_SKEQ_REG, 12'h010});
      run_op({OPC_SKNE_REG, 12'h010});
      run_op({OPC_RAND, 12'h2FF});
      run_op({OPC_LOAD_IMM, 12'h33C});
      run_op({OPC_LOAD_IMM, 12'h41E});
      run_op({4'hF, 4'h3, FX_FONT});
      run_op({OPC_DRAW, 12'h345});
      run_op({OPC_DRAW, 12'h345});
      run_op({OPC_DRAW, 12'h340});
      send_item(MODE_FRAME, 12'd190, 8'h00, 16'h0, 8'h0);
      run_op({OPC_LOAD_I, 12'hFFE});
      run_op({4'hF, 4'h0, FX_BCD});
      run_op({4'hF, 4'hF, FX_STORE});
      run_op({4'hF, 4'hF, FX_LOAD});
      run_op({4'hF, 4'h5, FX_ADD_I});
      run_op({OPC_KEY, 4'h3, KEY_DOWN}, 16'h0008);
      run_op({OPC_KEY, 4'h3, KEY_UP}, 16'h0008);
      run_op({OPC_KEY, 4'h3, 8'h55}, 16'h0008);
      run_op({4'hF, 4'h6, FX_WAIT_KEY}, 16'h0000);
      send_item(MODE_EXEC, 12'h0, 8'h0, 16'h8004, 8'h0);
      run_op({4'hF, 4'h6, FX_SET_DT});
      run_op({4'hF, 4'h7, FX_GET_DT});
      run_op({4'hF, 4'h4, FX_SET_ST});
      run_op({4'hF, 4'h4, 8'hFF});
      run_op(OP_CLS);
      run_op(16'h0123);
      run_op({OPC_JUMP_V0, 12'h400});
      run_op({OPC_JUMP, 12'h600});
   endtask

   // Calls that nest past the stack depth, then returns down past empty.
   task automatic test_stack();
      run_op({OPC_JUMP, 12'h300});
      for (int k = 0; k <= STACK_DEPTH; k++) run_op({OPC_CALL, 12'h300});
      send_item(MODE_WRITE, 12'h300, OP_RET[15:8], 16'h0, 8'h0);
      send_item(MODE_WRITE, 12'h301, OP_RET[7:0], 16'h0, 8'h0);
      for (int k = 0; k <= STACK_DEPTH; k++) run_op(OP_RET);
   endtask

   task automatic random_step();
      logic [15:0] op;
      int pick;
      if ($urandom_range(0, 9) < 3) begin
         pick = $urandom_range(0, 2);
         send_item(2'(pick), 12'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom_range(0, 254)));
         return;
      end
      op = 16'($urandom);
      case (op[15:12])
         OPC_SYS: op = ($urandom_range(0, 2) == 0) ? OP_CLS :
                       ($urandom_range(0, 1) == 0) ? OP_RET : op;
         OPC_JUMP, OPC_CALL: op[11:0] = 12'($urandom_range(12'h200, 12'hEFF));
         OPC_JUMP_V0: op[11:0] = 12'($urandom_range(12'h200, 12'hD00));
         OPC_DRAW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
         OPC_KEY: op[7:0] = ($urandom_range(0, 4) == 0) ? op[7:0] :
                            ($urandom_range(0, 1) == 0) ? KEY_DOWN : KEY_UP;
         4'hF: begin
            case ($urandom_range(0, 9))
               0: op[7:0] = FX_GET_DT;
               1: op[7:0] = FX_WAIT_KEY;
               2: op[7:0] = FX_SET_DT;
               3: op[7:0] = FX_SET_ST;
               4: op[7:0] = FX_ADD_I;
               5: op[7:0] = FX_FONT;
               6: op[7:0] = FX_BCD;
               7: op[7:0] = FX_STORE;
               8: op[7:0] = FX_LOAD;
               default: ;
            endcase
         end
         default: ;
      endcase
      // Keep the program well inside memory.
      if (shadow_pc > 13'hE00) op = {OPC_JUMP, 12'h200};
      run_op(op, rand_keys());
   endtask

   task automatic test_random(input int count);
      int start = beats_sent;
      while (beats_sent - start < count) random_step();
   endtask

   // Receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      hold_cycles = 400;
      repeat (10) random_step();
   endtask

   // Jump to the last byte: every later fetch faults, so this runs last.
   task automatic test_fetch_fault();
      run_op({OPC_JUMP, 12'hFFD});
      run_op({OPC_JUMP, 12'hFFF});
      send_item(MODE_EXEC, 12'h0, 8'h0, 16'h0, 8'h0);
      send_item(MODE_EXEC, 12'hABC, 8'h0, 16'h1, 8'h0);
      send_item(MODE_READ, 12'hFFF, 8'h0, 16'h0, 8'h0);
   endtask

   // Receiver stall: long hold-offs first, then random bursts.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (burst_cycles > 0) begin
         burst_cycles <= burst_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         burst_cycles <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each result beat against the oldest expectation; also the watchdog.
   always @(negedge clock) begin
      beat_type want, got;
      got = '{rsp_read_data, rsp_program_counter, rsp_executed_opcode,
              rsp_waiting_key, rsp_fault, rsp_sound_timer};
      if (!reset && rsp_valid && !rsp_stall) begin
         quiet_cycles <= 0;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: %p", got);
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch at beat %0d: expected %p, got %p",
                           beats_checked, want, got);
            end
         end
      end else if (!reset && req_valid && !req_stall) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 30000) begin
            $display("Timeout with %0d beats outstanding", expected_beats.size());
            $display("chip8_interpreter_core test failed");
            $finish;
         end
      end
   end

   initial begin
      foreach (shadow_mem[k]) shadow_mem[k] = 8'd0;
      foreach (FONT_ROM[k]) shadow_mem[FONT_BASE + k] = FONT_ROM[k];
      foreach (shadow_frame[k]) shadow_frame[k] = 8'd0;
      foreach (shadow_v[k]) shadow_v[k] = 8'd0;
      foreach (shadow_stack[k]) shadow_stack[k] = 13'd0;
      shadow_sp = 0;
      shadow_i = 16'd0;
      shadow_pc = PC_RESET;
      shadow_delay = 8'd0;
      shadow_sound = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_memory();
      test_instructions();
      test_stack();
      test_backpressure();
      test_random(550);
      idle_on = 1'b0;
      test_random(200);
      test_fetch_fault();
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d beats (memory, frame, every instruction group, stack and", beats_sent);
      $display("fetch faults, key waits, long receiver hold-off); checked %0d results.",
               beats_checked);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("chip8_interpreter_core test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("chip8_interpreter_core test failed");
      end
      $finish;
   end

endmodule
